### hdl/rvdec_pkg.sv
// rvdec_pkg.sv: shared opcode, funct and instruction code definitions for the rv32i decoder
`timescale 1ns / 1ps

package rvdec_pkg;

  // major opcodes
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_ALUI   = 7'h13;
  localparam logic [6:0] OP_ALUR   = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // load and store funct3
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_SB  = 3'd0;
  localparam logic [2:0] F3_SH  = 3'd1;
  localparam logic [2:0] F3_SW  = 3'd2;

  // alu funct3
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SLT = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_SRL = 3'd5;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;

  // csr funct3
  localparam logic [2:0] F3_CSRRW  = 3'd1;
  localparam logic [2:0] F3_CSRRS  = 3'd2;
  localparam logic [2:0] F3_CSRRC  = 3'd3;
  localparam logic [2:0] F3_CSRRWI = 3'd5;
  localparam logic [2:0] F3_CSRRSI = 3'd6;
  localparam logic [2:0] F3_CSRRCI = 3'd7;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  typedef enum logic [5:0] {
    INSN_ILLEGAL   = 6'd0,
    INSN_LUI       = 6'd1,
    INSN_AUIPC     = 6'd2,
    INSN_JAL       = 6'd3,
    INSN_JALR      = 6'd4,
    INSN_BEQ       = 6'd5,
    INSN_BNE       = 6'd6,
    INSN_BLT       = 6'd7,
    INSN_BGE       = 6'd8,
    INSN_BLTU      = 6'd9,
    INSN_BGEU      = 6'd10,
    INSN_LB        = 6'd11,
    INSN_LH        = 6'd12,
    INSN_LW        = 6'd13,
    INSN_LBU       = 6'd14,
    INSN_LHU       = 6'd15,
    INSN_SB        = 6'd16,
    INSN_SH        = 6'd17,
    INSN_SW        = 6'd18,
    INSN_ADDI      = 6'd19,
    INSN_SLTI      = 6'd20,
    INSN_SLTIU     = 6'd21,
    INSN_XORI      = 6'd22,
    INSN_ORI       = 6'd23,
    INSN_ANDI      = 6'd24,
    INSN_SLLI      = 6'd25,
    INSN_SRLI      = 6'd26,
    INSN_SRAI      = 6'd27,
    INSN_ADD       = 6'd28,
    INSN_SUB       = 6'd29,
    INSN_SLL       = 6'd30,
    INSN_SLT       = 6'd31,
    INSN_SLTU      = 6'd32,
    INSN_XOR       = 6'd33,
    INSN_SRL       = 6'd34,
    INSN_SRA       = 6'd35,
    INSN_OR        = 6'd36,
    INSN_AND       = 6'd37,
    INSN_ENV_CALL  = 6'd38,
    INSN_ENV_BREAK = 6'd39,
    INSN_CSRRW     = 6'd40,
    INSN_CSRRS     = 6'd41,
    INSN_CSRRC     = 6'd42,
    INSN_CSRRWI    = 6'd43,
    INSN_CSRRSI    = 6'd44,
    INSN_CSRRCI    = 6'd45
  } insn_code_e;

  typedef struct packed {
    insn_code_e  code;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic [11:0] csr;
    logic [31:0] target;
  } dec_res_t;

endpackage

### hdl/rvdec_decode.sv
// rvdec_decode.sv: combinational rv32i field decode and pc-relative target adder
`timescale 1ns / 1ps

module rvdec_decode (
  input  logic [31:0]        addr_i,
  input  logic [31:0]        word_i,
  output rvdec_pkg::dec_res_t res_o
);
  import rvdec_pkg::*;

  logic [6:0]  opcode;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] offset;
  logic [31:0] sum;
  insn_code_e  code;
  logic        use_rd;
  logic        use_rs1;
  logic        use_rs2;
  logic        use_csr;
  logic        use_tgt;
  logic [31:0] imm;

  assign opcode = word_i[6:0];
  assign f3     = word_i[14:12];
  assign f7     = word_i[31:25];

  assign imm_i = {{20{word_i[31]}}, word_i[31:20]};
  assign imm_s = {{20{word_i[31]}}, word_i[31:25], word_i[11:7]};
  assign imm_b = {{19{word_i[31]}}, word_i[31], word_i[7], word_i[30:25], word_i[11:8], 1'b0};
  assign imm_j = {{11{word_i[31]}}, word_i[31], word_i[19:12], word_i[20], word_i[30:21], 1'b0};

  // one shared adder for jal and branch targets
  assign offset = (opcode == OP_JAL) ? imm_j : imm_b;
  assign sum    = addr_i + offset;

  always_comb begin
    code    = INSN_ILLEGAL;
    imm     = '0;
    use_rd  = 1'b0;
    use_rs1 = 1'b0;
    use_rs2 = 1'b0;
    use_csr = 1'b0;
    use_tgt = 1'b0;
    case (opcode)
      OP_LUI: begin
        code   = INSN_LUI;
        use_rd = 1'b1;
        imm    = {12'd0, word_i[31:12]};
      end
      OP_AUIPC: begin
        code   = INSN_AUIPC;
        use_rd = 1'b1;
        imm    = {12'd0, word_i[31:12]};
      end
      OP_JAL: begin
        code    = INSN_JAL;
        use_rd  = 1'b1;
        use_tgt = 1'b1;
      end
      OP_JALR: begin
        code    = INSN_JALR;
        use_rd  = 1'b1;
        use_rs1 = 1'b1;
        imm     = imm_i;
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  code = INSN_BEQ;
          F3_BNE:  code = INSN_BNE;
          F3_BLT:  code = INSN_BLT;
          F3_BGE:  code = INSN_BGE;
          F3_BLTU: code = INSN_BLTU;
          F3_BGEU: code = INSN_BGEU;
          default: code = INSN_ILLEGAL;
        endcase
        if (code != INSN_ILLEGAL) begin
          use_rs1 = 1'b1;
          use_rs2 = 1'b1;
          use_tgt = 1'b1;
        end
      end
      OP_LOAD: begin
        case (f3)
          F3_LB:   code = INSN_LB;
          F3_LH:   code = INSN_LH;
          F3_LW:   code = INSN_LW;
          F3_LBU:  code = INSN_LBU;
          F3_LHU:  code = INSN_LHU;
          default: code = INSN_ILLEGAL;
        endcase
        if (code != INSN_ILLEGAL) begin
          use_rd  = 1'b1;
          use_rs1 = 1'b1;
          imm     = imm_i;
        end
      end
      OP_STORE: begin
        case (f3)
          F3_SB:   code = INSN_SB;
          F3_SH:   code = INSN_SH;
          F3_SW:   code = INSN_SW;
          default: code = INSN_ILLEGAL;
        endcase
        if (code != INSN_ILLEGAL) begin
          use_rs1 = 1'b1;
          use_rs2 = 1'b1;
          imm     = imm_s;
        end
      end
      OP_ALUI: begin
        // shifts carry the shift amount, taken from the rs2 field bits, in the immediate
        case (f3)
          F3_ADD:  code = INSN_ADDI;
          F3_SLT:  code = INSN_SLTI;
          F3_SLTU: code = INSN_SLTIU;
          F3_XOR:  code = INSN_XORI;
          F3_OR:   code = INSN_ORI;
          F3_AND:  code = INSN_ANDI;
          F3_SLL:  code = (f7 == F7_BASE) ? INSN_SLLI : INSN_ILLEGAL;
          F3_SRL: begin
            if (f7 == F7_BASE) begin
              code = INSN_SRLI;
            end else if (f7 == F7_ALT) begin
              code = INSN_SRAI;
            end else begin
              code = INSN_ILLEGAL;
            end
          end
          default: code = INSN_ILLEGAL;
        endcase
        if (code != INSN_ILLEGAL) begin
          use_rd  = 1'b1;
          use_rs1 = 1'b1;
          if (f3 == F3_SLL || f3 == F3_SRL) begin
            imm = {27'd0, word_i[24:20]};
          end else begin
            imm = imm_i;
          end
        end
      end
      OP_ALUR: begin
        // funct7 only matters for add/sub and the shifts
        case (f3)
          F3_ADD: begin
            if (f7 == F7_BASE) begin
              code = INSN_ADD;
            end else if (f7 == F7_ALT) begin
              code = INSN_SUB;
            end else begin
              code = INSN_ILLEGAL;
            end
          end
          F3_SLL:  code = (f7 == F7_BASE) ? INSN_SLL : INSN_ILLEGAL;
          F3_SRL: begin
            if (f7 == F7_BASE) begin
              code = INSN_SRL;
            end else if (f7 == F7_ALT) begin
              code = INSN_SRA;
            end else begin
              code = INSN_ILLEGAL;
            end
          end
          F3_SLT:  code = INSN_SLT;
          F3_SLTU: code = INSN_SLTU;
          F3_XOR:  code = INSN_XOR;
          F3_OR:   code = INSN_OR;
          F3_AND:  code = INSN_AND;
          default: code = INSN_ILLEGAL;
        endcase
        if (code != INSN_ILLEGAL) begin
          use_rd  = 1'b1;
          use_rs1 = 1'b1;
          use_rs2 = 1'b1;
        end
      end
      OP_SYSTEM: begin
        if (word_i == WORD_ECALL) begin
          code = INSN_ENV_CALL;
        end else if (word_i == WORD_EBREAK) begin
          code = INSN_ENV_BREAK;
        end else begin
          case (f3)
            F3_CSRRW:  code = INSN_CSRRW;
            F3_CSRRS:  code = INSN_CSRRS;
            F3_CSRRC:  code = INSN_CSRRC;
            F3_CSRRWI: code = INSN_CSRRWI;
            F3_CSRRSI: code = INSN_CSRRSI;
            F3_CSRRCI: code = INSN_CSRRCI;
            default:   code = INSN_ILLEGAL;
          endcase
          if (code != INSN_ILLEGAL) begin
            use_rd  = 1'b1;
            use_rs1 = 1'b1;
            use_csr = 1'b1;
          end
        end
      end
      default: code = INSN_ILLEGAL;
    endcase
  end

  always_comb begin
    res_o.code   = code;
    res_o.rd     = use_rd  ? word_i[11:7]  : 5'd0;
    res_o.rs1    = use_rs1 ? word_i[19:15] : 5'd0;
    res_o.rs2    = use_rs2 ? word_i[24:20] : 5'd0;
    res_o.imm    = imm;
    res_o.csr    = use_csr ? word_i[31:20] : 12'd0;
    res_o.target = use_tgt ? sum : 32'd0;
  end

endmodule

### hdl/rv32i_instruction_decoder_core.sv
// rv32i_instruction_decoder_core.sv: pipelined rv32i instruction decoder top level
`timescale 1ns / 1ps

// Usage:
// input channel: in_valid_i/in_ready_o carry one request of fetch_addr_i and
// insn_word_i. output channel: out_valid_o/out_ready_i carry the decoded
// instruction code, register fields, immediate, csr number and target.
// Two register stages: the request is captured in an input register, then
// decoded and the jal/branch target added in one pass into the result register.
// With no stall the request moves on from the input register into the result
// register, and out_valid_o rises as it is loaded there.
// Throughput is one request per cycle while the receiver keeps taking results;
// each stage refills in the cycle it empties, so a held result does not stop a
// request being taken while the input stage is free.
// When the receiver stalls, the result register holds its contents and the
// input stage holds the next request; in_ready_o drops only when both are full.
// Reset clears both stage valid flags; nothing is in flight afterwards.
module rv32i_instruction_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        fetch_addr_i,
  input  logic [31:0]        insn_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         insn_code_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src1_reg_o,
  output logic [4:0]         src2_reg_o,
  output logic signed [31:0] immediate_o,
  output logic [11:0]        csr_number_o,
  output logic [31:0]        target_addr_o
);
  import rvdec_pkg::*;

  logic        in_vld_q;
  logic        in_vld_d;
  logic [31:0] addr_q;
  logic [31:0] word_q;
  logic        out_vld_q;
  logic        out_vld_d;
  logic        out_free;
  dec_res_t    dec_res;
  dec_res_t    res_q;

  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = !in_vld_q || out_free;

  assign in_vld_d  = in_ready_o ? in_valid_i : in_vld_q;
  assign out_vld_d = out_free ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      addr_q <= fetch_addr_i;
      word_q <= insn_word_i;
    end
  end

  rvdec_decode u_decode (
    .addr_i (addr_q),
    .word_i (word_q),
    .res_o  (dec_res)
  );

  always_ff @(posedge clk_i) begin
    if (in_vld_q && out_free) begin
      res_q <= dec_res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign insn_code_o   = res_q.code;
  assign dest_reg_o    = res_q.rd;
  assign src1_reg_o    = res_q.rs1;
  assign src2_reg_o    = res_q.rs2;
  assign immediate_o   = $signed(res_q.imm);
  assign csr_number_o  = res_q.csr;
  assign target_addr_o = res_q.target;

`ifndef SYNTHESIS
  // back-pressure only comes from a stalled result register
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // an illegal word leaves every field zero
  a_illegal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && insn_code_o == INSN_ILLEGAL) |->
    (dest_reg_o == 5'd0 && src1_reg_o == 5'd0 && src2_reg_o == 5'd0 &&
     immediate_o == 32'sd0 && csr_number_o == 12'd0 && target_addr_o == 32'd0))
    else $error("illegal result carries non-zero fields");

  // only jal and branches produce a target
  a_target_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && target_addr_o != 32'd0) |->
    (insn_code_o == INSN_JAL || insn_code_o == INSN_BEQ || insn_code_o == INSN_BNE ||
     insn_code_o == INSN_BLT || insn_code_o == INSN_BGE || insn_code_o == INSN_BLTU ||
     insn_code_o == INSN_BGEU))
    else $error("target on a non-control-transfer instruction");

  // csr number only for csr instructions
  a_csr_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && csr_number_o != 12'd0) |->
    (insn_code_o == INSN_CSRRW || insn_code_o == INSN_CSRRS || insn_code_o == INSN_CSRRC ||
     insn_code_o == INSN_CSRRWI || insn_code_o == INSN_CSRRSI ||
     insn_code_o == INSN_CSRRCI))
    else $error("csr number on a non-csr instruction");
`endif

endmodule
